// ----- src/frl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fraction reducer package
// Shared widths, item types, status codes and the controller/datapath link.
// ----------------------------------------------------------------------------
package frl_pkg;

    localparam int DATA_W            = 32;
    localparam int STATUS_W          = 2;
    localparam int CFG_INDEX_W       = 8;
    localparam int OPERAND_WIDTH_DEF = 32;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_NUM_LIMIT = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_DEN_LIMIT = CFG_INDEX_W'(1);

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_LIMIT     = 2'd1,
        STATUS_BOTH_ZERO = 2'd2
    } status_t;

    typedef struct packed {
        logic [DATA_W-1:0] numerator_in;
        logic [DATA_W-1:0] denominator_in;
    } in_item_t;

    typedef struct packed {
        logic [DATA_W-1:0]   numerator_out;
        logic [DATA_W-1:0]   denominator_out;
        logic [STATUS_W-1:0] status;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic gcd_step;
        logic save_gcd;
        logic div_load;
        logic div_sel_den;
        logic div_step;
        logic save_num;
        logic write_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic req_both_zero;
        logic gcd_done;
        logic div_last;
    } sts_t;

endpackage

// ----- src/frl_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fraction reducer datapath
// Limit registers, binary GCD unit, shared restoring divider and result register.
// ----------------------------------------------------------------------------
module frl_datapath #(
    parameter int OPERAND_WIDTH = frl_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  frl_pkg::cmd_t                    cmd,
    output frl_pkg::sts_t                    sts,
    input  frl_pkg::in_item_t                req_item,
    output frl_pkg::out_item_t               rsp_item,
    input  logic                             cfg_write,
    input  logic [frl_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [frl_pkg::DATA_W-1:0]       cfg_data
);
    import frl_pkg::*;

    localparam int W     = OPERAND_WIDTH;
    localparam int SH_W  = $clog2(W);
    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     num_lim_reg, den_lim_reg;
    logic [W-1:0]     num_reg, den_reg;
    logic [W-1:0]     x_reg, x_next;
    logic [W-1:0]     y_reg, y_next;
    logic [SH_W-1:0]  sh_reg, sh_next;
    logic [W-1:0]     g_reg;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     rn_reg;
    out_item_t        out_reg, out_next;

    logic [W-1:0]     req_num, req_den;
    logic [W:0]       trial;
    logic [W:0]       trial_diff;

    assign req_num = W'(req_item.numerator_in);
    assign req_den = W'(req_item.denominator_in);

    assign sts.req_both_zero = (req_num == '0) && (req_den == '0);
    assign sts.gcd_done      = (x_reg == '0) || (y_reg == '0);
    assign sts.div_last      = (cnt_reg == '0);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_lim_reg <= '1;
            den_lim_reg <= '1;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_NUM_LIMIT)
            begin
                num_lim_reg <= W'(cfg_data);
            end
            else if (cfg_index == REG_DEN_LIMIT)
            begin
                den_lim_reg <= W'(cfg_data);
            end
        end
    end

    // One binary GCD step: halve the even operands, otherwise subtract the
    // smaller odd value from the larger.
    always_comb
    begin
        x_next  = x_reg;
        y_next  = y_reg;
        sh_next = sh_reg;
        if (!x_reg[0] && !y_reg[0])
        begin
            x_next  = x_reg >> 1;
            y_next  = y_reg >> 1;
            sh_next = sh_reg + SH_W'(1);
        end
        else if (!x_reg[0])
        begin
            x_next = x_reg >> 1;
        end
        else if (!y_reg[0])
        begin
            y_next = y_reg >> 1;
        end
        else if (x_reg > y_reg)
        begin
            x_next = y_reg;
            y_next = x_reg - y_reg;
        end
        else
        begin
            y_next = y_reg - x_reg;
        end
    end

    // One restoring division step, one quotient bit per cycle.
    always_comb
    begin
        trial      = {rem_reg, quo_reg[W-1]};
        trial_diff = trial - {1'b0, g_reg};
        if (!trial_diff[W])
        begin
            rem_next = trial_diff[W-1:0];
            quo_next = {quo_reg[W-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[W-1:0];
            quo_next = {quo_reg[W-2:0], 1'b0};
        end
    end

    // Result formatting; the denominator quotient is in quo_reg at this point.
    always_comb
    begin
        out_next = out_reg;
        if ((num_reg == '0) && (den_reg == '0))
        begin
            out_next.numerator_out   = '0;
            out_next.denominator_out = '0;
            out_next.status          = STATUS_BOTH_ZERO;
        end
        else if ((rn_reg > num_lim_reg) || (quo_reg > den_lim_reg))
        begin
            out_next.numerator_out   = '0;
            out_next.denominator_out = '0;
            out_next.status          = STATUS_LIMIT;
        end
        else
        begin
            out_next.numerator_out   = DATA_W'(rn_reg);
            out_next.denominator_out = DATA_W'(quo_reg);
            out_next.status          = STATUS_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            num_reg <= req_num;
            den_reg <= req_den;
            x_reg   <= req_num;
            y_reg   <= req_den;
            sh_reg  <= '0;
        end
        else if (cmd.gcd_step)
        begin
            x_reg  <= x_next;
            y_reg  <= y_next;
            sh_reg <= sh_next;
        end

        // A zero numerator leaves the divisor in y; otherwise restore the
        // common power of two.
        if (cmd.save_gcd)
        begin
            g_reg <= (x_reg == '0) ? y_reg : (x_reg << sh_reg);
        end

        if (cmd.div_load)
        begin
            rem_reg <= '0;
            quo_reg <= cmd.div_sel_den ? den_reg : num_reg;
            cnt_reg <= CNT_W'(W - 1);
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            cnt_reg <= cnt_reg - CNT_W'(1);
        end

        if (cmd.save_num)
        begin
            rn_reg <= quo_reg;
        end

        if (cmd.write_out)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp_item = out_reg;

endmodule

// ----- src/frl_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fraction reducer controller
// Sequences load, GCD, two divisions and result hand-over for one item.
// ----------------------------------------------------------------------------
module frl_controller (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output frl_pkg::cmd_t cmd,
    input  frl_pkg::sts_t sts
);
    import frl_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_GCD  = 6'b000010,
        S_DIVN = 6'b000100,
        S_SETD = 6'b001000,
        S_DIVD = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   slot_free;

    assign slot_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        req_ready      = 1'b0;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.req_both_zero ? S_OUT : S_GCD;
                end
            end
            S_GCD:
            begin
                if (sts.gcd_done)
                begin
                    cmd.save_gcd = 1'b1;
                    cmd.div_load = 1'b1;
                    state_next   = S_DIVN;
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                end
            end
            S_DIVN:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_SETD;
                end
            end
            S_SETD:
            begin
                cmd.save_num    = 1'b1;
                cmd.div_load    = 1'b1;
                cmd.div_sel_den = 1'b1;
                state_next      = S_DIVD;
            end
            S_DIVD:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    cmd.write_out  = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

// ----- src/fraction_reducer_with_limits.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fraction reducer with limits
// Reduces an unsigned fraction to lowest terms and checks it against limits.
// ----------------------------------------------------------------------------
// Each item carries a numerator and a denominator; the block finds their
// greatest common divisor with an iterative binary GCD (one halving or one
// subtraction per cycle), then divides both values by it on a single shared
// restoring divider that produces one quotient bit per cycle, numerator first.
// A zero input makes the other input the divisor, so 0/d gives 0/1 and n/0
// gives 1/0; two zero inputs give 0/0 with the both-zero status and no limit
// check. If the reduced numerator or denominator is above its limit register,
// both outputs are zero and the status reports the limit. One item is worked
// on at a time: an item is loaded, the GCD loop steps until one operand is
// zero, the divisor is latched as the numerator division is loaded, the
// divider works out the numerator quotient, the numerator result is saved as
// the denominator division is loaded, the divider works out the denominator
// quotient and the result is written once the output register is free. Two
// zero inputs skip the GCD loop and the divider. The result sits in an
// output register, so a new item is accepted while the previous result still
// waits to be taken. Both limit registers reset to all ones and may be
// written whenever the block is idle; writes to other indexes are ignored.
// ----------------------------------------------------------------------------
module fraction_reducer_with_limits #(
    parameter int OPERAND_WIDTH = frl_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,

    // Request channel: one fraction per item.
    input  logic                             req_valid,
    output logic                             req_ready,
    input  frl_pkg::in_item_t                req_item,

    // Response channel: one reduced fraction and status per item.
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output frl_pkg::out_item_t               rsp_item,

    // Configuration write channel.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [frl_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [frl_pkg::DATA_W-1:0]       cfg_data
);
    import frl_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // The limit registers can take a write in any cycle.
    assign cfg_ready = 1'b1;

    frl_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    frl_datapath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req_item  (req_item),
        .rsp_item  (rsp_item),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
